// ----- design/assert_macros.svh -----
// Assertion macros shared by the hash table RTL.
// Expects signals clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OAHT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define OAHT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define OAHT_ASSERT(lbl, prop, msg)
`define OAHT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- design/oaht_pkg.sv -----
// Constants and codes for the open addressing hash table.
// No dependencies.
package oaht_pkg;
	localparam int DEPTH = 1024;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int DVD_W = KEY_W;
	localparam int DVS_W = CNT_W;
	localparam int CFG_W = 11;
	localparam int HASH_MUL = 61;
	localparam int HASH_DIV = 100;
	// floor(x / 100) as (x * RCP) >> SH, exact over the ranges used
	localparam int RCP100_NARROW = 5243;
	localparam int SH100_NARROW = 19;
	localparam int RCP100_WIDE = 167773;
	localparam int SH100_WIDE = 24;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_MODIFY = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_KEYZERO = 2'd3;

	localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
	localparam logic [1:0] REG_HASH_MODE = 2'd1;
	localparam logic [1:0] REG_PROBE_MODE = 2'd2;
endpackage

// ----- design/oaht_ifs.sv -----
// Request, response and configuration channels of the hash table.
// Depends on oaht_pkg.
interface oaht_req_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [oaht_pkg::KEY_W-1:0] key;
	logic [oaht_pkg::VAL_W-1:0] value;
	modport source (output valid, op, key, value, input ready);
	modport sink (input valid, op, key, value, output ready);
endinterface

interface oaht_rsp_if;
	logic valid;
	logic ready;
	logic found;
	logic [oaht_pkg::IDX_W-1:0] slot;
	logic [oaht_pkg::VAL_W-1:0] data;
	logic [1:0] status;
	logic [oaht_pkg::CNT_W-1:0] probes;
	modport source (output valid, found, slot, data, status, probes, input ready);
	modport sink (input valid, found, slot, data, status, probes, output ready);
endinterface

interface oaht_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [oaht_pkg::CFG_W-1:0] wdata;
	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

// ----- design/oaht_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module oaht_ram #(
	parameter int W = 32,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- design/oaht_div.sv -----
// Bit-serial restoring divider, one bit per cycle, remainder output.
// Depends on oaht_pkg.
module oaht_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [oaht_pkg::DVD_W-1:0]   dividend,
	input  logic [oaht_pkg::DVS_W-1:0]   divisor,
	output logic                         done,
	output logic [oaht_pkg::DVS_W-1:0]   rem
);
	import oaht_pkg::*;

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;
	logic busy_q;
	logic done_q;
	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic take;

	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		diff = trial - {1'b0, dvs_q};
		take = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], take};
			rem_q <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done = done_q;
	assign rem = rem_q;
endmodule

// ----- design/open_addressing_hash_table.sv -----
// Open addressing hash table: top level, request sequencer and probe walk.
// Depends on oaht_pkg, oaht_ifs, oaht_ram, oaht_div and assert_macros.svh.
//
// Keys and values live in two 1024-entry RAMs with registered reads. After
// reset a clearing pass zeroes the key RAM, during which no request is taken.
// A request first computes its home slot: the modulo hash runs through a
// bit-serial divider, the multiplicative hash through an eight-stage pipeline.
// Each probe then takes a RAM read followed by compare and step; a zero key
// is rejected without hashing or probing. The response sits in an output
// register, so a new request can start while the previous response waits; a
// second finished response stalls until that register is taken.
`include "assert_macros.svh"
module open_addressing_hash_table (
	input logic   clk,
	input logic   arst_n,
	oaht_req_if.sink   req,
	oaht_rsp_if.source rsp,
	oaht_cfg_if.sink   cfg
);
	import oaht_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_DIV1, S_HASH, S_READ, S_CHECK, S_DONE
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] clr_q;
	logic [CFG_W-1:0] size_cfg_q;
	logic hmode_cfg_q;
	logic pmode_cfg_q;
	logic [CNT_W-1:0] used_q;

	logic [1:0] op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [CNT_W-1:0] m_q;
	logic pmode_q;
	logic [IDX_W-1:0] cur_q;
	logic [CNT_W-1:0] n_q;

	logic res_found_q;
	logic [IDX_W-1:0] res_slot_q;
	logic [VAL_W-1:0] res_data_q;
	logic [1:0] res_status_q;
	logic [CNT_W-1:0] res_probes_q;

	logic out_valid_q;
	logic out_found_q;
	logic [IDX_W-1:0] out_slot_q;
	logic [VAL_W-1:0] out_data_q;
	logic [1:0] out_status_q;
	logic [CNT_W-1:0] out_probes_q;

	logic div_start;
	logic [DVD_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic div_done;
	logic [DVS_W-1:0] div_rem;

	logic hash_start;
	logic hash_done;
	logic [7:0] hvld_q;
	logic [14:0] hx_s1;
	logic [14:0] hx_s2;
	logic [8:0] hq_s2;
	logic [6:0] hr_s3;
	logic [12:0] hy_s4;
	logic [12:0] hy_s5;
	logic [5:0] hq_s5;
	logic [6:0] hf_s6;
	logic [CNT_W+6:0] hp_s7;
	logic [IDX_W-1:0] hh_s8;
	logic [27:0] hx_prod;
	logic [24:0] hy_prod;
	logic [CNT_W+24:0] hp_prod;

	logic key_we;
	logic [IDX_W-1:0] key_waddr;
	logic [KEY_W-1:0] key_wdata;
	logic [KEY_W-1:0] key_rd;
	logic val_we;
	logic [VAL_W-1:0] val_wdata;
	logic [VAL_W-1:0] val_rd;

	logic [CNT_W-1:0] m_in;
	logic req_acc;
	logic hit;
	logic empty;
	logic last;
	logic [CNT_W-1:0] n_next;
	logic [IDX_W-1:0] cur_next;
	logic [CNT_W+1:0] qsum;
	logic [CNT_W+1:0] qred;
	logic [CNT_W+1:0] qred2;
	logic [CNT_W-1:0] lin;
	logic ins_ok;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign req_acc = req.valid && req.ready;

	always_comb begin
		if (size_cfg_q == '0) begin
			m_in = CNT_W'(1);
		end else if (size_cfg_q > CFG_W'(DEPTH)) begin
			m_in = CNT_W'(DEPTH);
		end else begin
			m_in = CNT_W'(size_cfg_q);
		end
	end

	always_comb begin
		hit = (key_rd == key_q);
		empty = (key_rd == '0);
		n_next = n_q + 1'b1;
		last = (n_next == m_q);
		lin = {1'b0, cur_q} + 1'b1;
		qsum = (CNT_W+2)'(cur_q) + (CNT_W+2)'({n_q, 1'b1});
		qred = (qsum >= (CNT_W+2)'(m_q)) ? qsum - (CNT_W+2)'(m_q) : qsum;
		qred2 = (qred >= (CNT_W+2)'(m_q)) ? qred - (CNT_W+2)'(m_q) : qred;
		if (pmode_q) begin
			cur_next = qred2[IDX_W-1:0];
		end else begin
			cur_next = (lin == m_q) ? '0 : lin[IDX_W-1:0];
		end
		ins_ok = hit || (empty && (used_q < m_q));
	end

	assign div_start = req_acc && (req.key != '0) && !hmode_cfg_q;
	assign div_dvd = req.key;
	assign div_dvs = m_in;
	assign hash_start = req_acc && (req.key != '0) && hmode_cfg_q;
	assign hash_done = hvld_q[7];

	// multiplicative hash: floor(((key * 61) mod 100) * m / 100)
	always_comb begin
		hx_prod = 28'(hx_s1) * 28'(RCP100_NARROW);
		hy_prod = 25'(hy_s4) * 25'(RCP100_NARROW);
		hp_prod = (CNT_W+25)'(hp_s7) * (CNT_W+25)'(RCP100_WIDE);
	end

	always_ff @(posedge clk) begin
		// key mod 100 folded by bytes: 256^i mod 100 is 1, 56, 36, 16
		hx_s1 <= 15'(req.key[7:0]) + 15'(req.key[15:8]) * 15'(56) +
			15'(req.key[23:16]) * 15'(36) + 15'(req.key[31:24]) * 15'(16);
		hx_s2 <= hx_s1;
		hq_s2 <= hx_prod[SH100_NARROW +: 9];
		hr_s3 <= 7'(hx_s2 - 15'(hq_s2) * 15'(HASH_DIV));
		hy_s4 <= 13'(hr_s3) * 13'(HASH_MUL);
		hy_s5 <= hy_s4;
		hq_s5 <= hy_prod[SH100_NARROW +: 6];
		hf_s6 <= 7'(hy_s5 - 13'(hq_s5) * 13'(HASH_DIV));
		hp_s7 <= (CNT_W+7)'(hf_s6) * (CNT_W+7)'(m_q);
		hh_s8 <= hp_prod[SH100_WIDE +: IDX_W];
	end

	always_comb begin
		key_we = 1'b0;
		key_waddr = cur_q;
		key_wdata = key_q;
		val_we = 1'b0;
		val_wdata = val_q;
		if (state_q == S_CLEAR) begin
			key_we = 1'b1;
			key_waddr = clr_q;
			key_wdata = '0;
		end else if (state_q == S_CHECK && (hit || empty)) begin
			if (op_q == OP_INSERT) begin
				key_we = ins_ok && !hit;
				val_we = ins_ok;
			end else if (hit && op_q == OP_DELETE) begin
				key_we = 1'b1;
				key_wdata = '0;
				val_we = 1'b1;
				val_wdata = '0;
			end else if (hit && op_q == OP_MODIFY) begin
				val_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			size_cfg_q <= CFG_W'(DEPTH);
			hmode_cfg_q <= 1'b0;
			pmode_cfg_q <= 1'b0;
			used_q <= '0;
			out_valid_q <= 1'b0;
			hvld_q <= '0;
		end else begin
			hvld_q <= {hvld_q[6:0], hash_start};
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_TABLE_SIZE: size_cfg_q <= cfg.wdata;
					REG_HASH_MODE:  hmode_cfg_q <= cfg.wdata[0];
					REG_PROBE_MODE: pmode_cfg_q <= cfg.wdata[0];
					default: ;
				endcase
			end
			if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_acc) begin
						state_q <= (req.key == '0) ? S_DONE :
							(hmode_cfg_q ? S_HASH : S_DIV1);
					end
				end
				S_DIV1: begin
					if (div_done) begin
						state_q <= S_READ;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (hit || empty || last) begin
						state_q <= S_DONE;
						if (op_q == OP_INSERT && !hit && empty && ins_ok) begin
							used_q <= used_q + 1'b1;
						end else if (op_q == OP_DELETE && hit && used_q != '0) begin
							used_q <= used_q - 1'b1;
						end
					end else begin
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q <= req.op;
				key_q <= req.key;
				val_q <= req.value;
				m_q <= m_in;
				pmode_q <= pmode_cfg_q;
				n_q <= '0;
				res_found_q <= 1'b0;
				res_slot_q <= '0;
				res_data_q <= '0;
				res_status_q <= ST_KEYZERO;
				res_probes_q <= '0;
			end
			S_DIV1: begin
				if (div_done) begin
					cur_q <= div_rem[IDX_W-1:0];
				end
			end
			S_HASH: begin
				if (hash_done) begin
					cur_q <= hh_s8;
				end
			end
			S_CHECK: begin
				res_probes_q <= n_next;
				if (op_q == OP_INSERT) begin
					res_found_q <= ins_ok;
					res_slot_q <= ins_ok ? cur_q : '0;
					res_status_q <= ins_ok ? ST_OK : ST_FULL;
				end else begin
					res_found_q <= hit;
					res_slot_q <= hit ? cur_q : '0;
					res_status_q <= hit ? ST_OK : ST_MISS;
					res_data_q <= (hit && op_q == OP_LOOKUP) ? val_rd : '0;
				end
				n_q <= n_next;
				cur_q <= cur_next;
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_found_q <= res_found_q;
					out_slot_q <= res_slot_q;
					out_data_q <= res_data_q;
					out_status_q <= res_status_q;
					out_probes_q <= res_probes_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.found = out_found_q;
	assign rsp.slot = out_slot_q;
	assign rsp.data = out_data_q;
	assign rsp.status = out_status_q;
	assign rsp.probes = out_probes_q;

	oaht_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.rem      (div_rem)
	);

	oaht_ram #(.W(KEY_W), .D(DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.raddr (cur_q),
		.rdata (key_rd)
	);

	oaht_ram #(.W(VAL_W), .D(DEPTH)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (cur_q),
		.wdata (val_wdata),
		.raddr (cur_q),
		.rdata (val_rd)
	);

	`OAHT_ASSERT(a_used_bound, used_q <= CNT_W'(DEPTH), "used count above depth")
	`OAHT_ASSERT(a_found_ok, rsp.valid |-> (rsp.found == (rsp.status == ST_OK)), "found vs status")
	`OAHT_ASSERT(a_keyzero, (rsp.valid && rsp.status == ST_KEYZERO) |-> (rsp.probes == '0), "rejected key probed")
	`OAHT_NEVER(a_probe_over, state_q == S_CHECK && n_q >= m_q, "probe count past table size")
endmodule
